// ----- rtl/mlpq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlpq_pkg
// Shared types and constants of the multilevel priority ready queues.
// ----------------------------------------------------------------------------
package mlpq_pkg;

    localparam int NUM_LEVELS = 3;

    localparam logic [7:0] PRIO_MAX    = 8'd139;
    localparam logic [7:0] PRIO_LVL1   = 8'd100;
    localparam logic [7:0] PRIO_LVL2   = 8'd130;
    localparam logic [7:0] PRIO_SLICE  = 8'd120;
    localparam logic [7:0] PRIO_BASE   = 8'd140;
    localparam logic [7:0] PRIO_FLOOR  = 8'd100;
    localparam logic [7:0] PRIO_BONUS  = 8'd105;

    localparam logic [2:0] ST_ENQUEUED = 3'd0;
    localparam logic [2:0] ST_DISPATCH = 3'd1;
    localparam logic [2:0] ST_NO_TASK  = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_BAD_PRIO = 3'd4;

    localparam logic ACT_ENQUEUE  = 1'b0;
    localparam logic ACT_DISPATCH = 1'b1;

    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_INSERT = 2'd1,
        OP_UPDATE = 2'd2,
        OP_REMOVE = 2'd3
    } mlpq_op_t;

    typedef struct packed {
        logic        valid;
        logic [15:0] task_id;
        logic [7:0]  sprio;
        logic [15:0] exec_time;
        logic [15:0] remain;
        logic [11:0] last_slice;
        logic [31:0] accum;
    } mlpq_entry_t;

    typedef struct packed {
        mlpq_op_t    op;
        mlpq_entry_t ent;
    } mlpq_cmd_t;

endpackage

// ----- rtl/mlpq_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlpq_cell
// One slot of a sorted ready queue; shifts toward its neighbors.
// ----------------------------------------------------------------------------
module mlpq_cell #(
    parameter bit IS_HEAD = 1'b0
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  mlpq_pkg::mlpq_cmd_t  cmd,
    input  mlpq_pkg::mlpq_entry_t left_ent,
    input  logic                 left_le,
    input  mlpq_pkg::mlpq_entry_t right_ent,
    output mlpq_pkg::mlpq_entry_t ent,
    output logic                 le
);
    import mlpq_pkg::*;

    mlpq_entry_t ent_reg;
    mlpq_entry_t ent_next;

    assign ent = ent_reg;
    assign le  = ent_reg.valid && (ent_reg.sprio <= cmd.ent.sprio);

    always_comb begin
        ent_next = ent_reg;
        case (cmd.op)
            OP_INSERT: begin
                if (!le) begin
                    ent_next = left_le ? cmd.ent : left_ent;
                end
            end
            OP_UPDATE: begin
                if (IS_HEAD) begin
                    ent_next = cmd.ent;
                end
            end
            OP_REMOVE: ent_next = right_ent;
            default:   ent_next = ent_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_reg <= '0;
        end else begin
            ent_reg <= ent_next;
        end
    end

endmodule

// ----- rtl/mlpq_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlpq_queue
// One ready queue: a chain of cells kept sorted by static priority.
// ----------------------------------------------------------------------------
module mlpq_queue #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  mlpq_pkg::mlpq_cmd_t   cmd,
    output mlpq_pkg::mlpq_entry_t head,
    output logic                  full
);
    import mlpq_pkg::*;

    mlpq_entry_t ents [QUEUE_DEPTH];
    logic        les  [QUEUE_DEPTH];

    genvar i;
    generate
        for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
            mlpq_entry_t lft;
            mlpq_entry_t rgt;
            logic        lft_le;
            if (i == 0) begin : g_first
                assign lft    = '0;
                assign lft_le = 1'b1;
            end else begin : g_mid
                assign lft    = ents[i-1];
                assign lft_le = les[i-1];
            end
            if (i == QUEUE_DEPTH - 1) begin : g_last
                assign rgt = '0;
            end else begin : g_inner
                assign rgt = ents[i+1];
            end
            mlpq_cell #(.IS_HEAD(i == 0)) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .cmd       (cmd),
                .left_ent  (lft),
                .left_le   (lft_le),
                .right_ent (rgt),
                .ent       (ents[i]),
                .le        (les[i])
            );
        end
    endgenerate

    assign head = ents[0];
    assign full = ents[QUEUE_DEPTH-1].valid;

endmodule

// ----- rtl/multilevel_priority_ready_queues.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multilevel_priority_ready_queues
// Per-core three-level sorted ready queues with enqueue and dispatch.
//
// s_ channel takes one request per item: s_tuser is the action (enqueue or
// dispatch), s_tdata carries task id, priority, execution time and core.
// m_ channel returns one result per request: m_tuser is the status, m_tdata
// the task id, level, slice, dynamic priority, remaining and accumulated time.
// A request is latched into the input registers and then executed, so the
// block takes no new item until the current one has executed; the result
// is held in the output register. The execute step waits while the output
// register still holds an untaken result, so a stalled receiver holds the
// block after one further item. Every queue is a chain of cells that
// inserts, updates its head or shifts out as its command selects.
// Reset empties all queues at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module multilevel_priority_ready_queues #(
    parameter int NUM_CORES   = 4,
    parameter int QUEUE_DEPTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // task_id[15:0], priority_req[23:16], exec_time[39:24], core[41:40]
    input  logic [47:0] s_tdata,
    // action
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_task_id[15:0], level[17:16], slice_len[29:18],
    // dyn_prio[37:30], rem_time[53:38], accum_time[85:54],
    // completed[86]
    output logic [87:0] m_tdata,
    // status
    output logic [2:0]  m_tuser
);
    import mlpq_pkg::*;

    localparam int NQ = NUM_CORES * NUM_LEVELS;
    localparam int QW = $clog2(NQ);

    logic        busy_reg;
    logic        act_reg;
    logic [15:0] tid_reg;
    logic [7:0]  prio_reg;
    logic [15:0] et_reg;
    logic [1:0]  core_reg;

    logic        mval_reg;
    logic [87:0] mdata_reg;
    logic [2:0]  muser_reg;

    mlpq_cmd_t   cmds  [NQ];
    mlpq_entry_t heads [NQ];
    logic        fulls [NQ];

    logic        fire;
    logic        core_ok;
    logic [1:0]  lvl;
    logic [QW-1:0] qsel;
    logic [5:0]  qsum;
    logic [5:0]  hidx;
    mlpq_op_t    op_sel;
    mlpq_entry_t ent_sel;
    mlpq_entry_t hd;
    logic        found;
    logic [7:0]  prio_gap;
    logic [11:0] slice;
    logic [15:0] rem;
    logic [32:0] acc_sum;
    logic [31:0] acc;
    logic [7:0]  dp;
    logic        bonus10;
    logic [2:0]  st_next;
    logic [87:0] data_next;

    assign fire     = busy_reg && (!mval_reg || m_tready);
    assign s_tready = !busy_reg;
    assign m_tvalid = mval_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;
    assign core_ok  = 32'(core_reg) < NUM_CORES;

    always_comb begin
        lvl     = 2'd0;
        found   = 1'b0;
        hd      = '0;
        qsum    = 6'd0;
        hidx    = 6'd0;
        op_sel  = OP_NONE;
        ent_sel = '0;
        st_next = ST_NO_TASK;
        data_next = '0;
        prio_gap = '0;
        slice   = '0;
        rem     = '0;
        acc_sum = '0;
        acc     = '0;
        dp      = '0;
        bonus10 = 1'b0;
        if (act_reg == ACT_ENQUEUE) begin
            lvl = (prio_reg < PRIO_LVL1) ? 2'd0 : ((prio_reg < PRIO_LVL2) ? 2'd1 : 2'd2);
            qsum = {4'd0, core_reg} * 6'd3 + {4'd0, lvl};
            data_next[15:0] = tid_reg;
            if (prio_reg > PRIO_MAX) begin
                st_next = ST_BAD_PRIO;
            end else if (!core_ok) begin
                st_next = ST_FULL;
            end else if (fulls[qsum[QW-1:0]]) begin
                st_next = ST_FULL;
                data_next[17:16] = lvl;
            end else begin
                st_next = ST_ENQUEUED;
                op_sel  = OP_INSERT;
                ent_sel = '{valid: 1'b1, task_id: tid_reg, sprio: prio_reg,
                            exec_time: et_reg, remain: et_reg, last_slice: 12'd0,
                            accum: 32'd0};
                data_next[17:16] = lvl;
                data_next[37:30] = prio_reg;
                data_next[53:38] = et_reg;
            end
        end else begin
            if (core_ok) begin
                for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
                    hidx = {4'd0, core_reg} * 6'd3 + 6'(l);
                    if (heads[hidx[QW-1:0]].valid) begin
                        found = 1'b1;
                        lvl   = 2'(l);
                    end
                end
            end
            qsum = {4'd0, core_reg} * 6'd3 + {4'd0, lvl};
            hd   = heads[qsum[QW-1:0]];
            if (found) begin
                prio_gap = PRIO_BASE - hd.sprio;
                slice = (hd.sprio < PRIO_SLICE) ? 12'(prio_gap) * 12'd20
                                                : 12'(prio_gap) * 12'd5;
                rem   = (hd.remain > {4'd0, slice}) ? hd.remain - {4'd0, slice} : 16'd0;
                acc_sum = {1'b0, hd.accum} + {21'd0, slice};
                acc   = acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
                bonus10 = hd.exec_time < {4'd0, hd.last_slice};
                if (bonus10) begin
                    dp = (hd.sprio < PRIO_BONUS) ? PRIO_FLOOR : hd.sprio - 8'd5;
                end else begin
                    dp = (hd.sprio < PRIO_FLOOR) ? PRIO_FLOOR : hd.sprio;
                end
                st_next = ST_DISPATCH;
                op_sel  = (rem == 16'd0) ? OP_REMOVE : OP_UPDATE;
                ent_sel = hd;
                ent_sel.remain     = rem;
                ent_sel.last_slice = slice;
                ent_sel.accum      = acc;
                data_next[15:0]  = hd.task_id;
                data_next[17:16] = lvl;
                data_next[29:18] = slice;
                data_next[37:30] = dp;
                data_next[53:38] = rem;
                data_next[85:54] = acc;
                data_next[86]    = (rem == 16'd0);
            end
        end
        qsel = qsum[QW-1:0];
    end

    genvar q;
    generate
        for (q = 0; q < NQ; q++) begin : g_queue
            always_comb begin
                cmds[q].ent = ent_sel;
                cmds[q].op  = (fire && qsel == QW'(q)) ? op_sel : OP_NONE;
            end
            mlpq_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
                .aclk    (aclk),
                .aresetn (aresetn),
                .cmd     (cmds[q]),
                .head    (heads[q]),
                .full    (fulls[q])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            mval_reg <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                busy_reg <= 1'b1;
            end else if (fire) begin
                busy_reg <= 1'b0;
            end
            if (fire) begin
                mval_reg <= 1'b1;
            end else if (m_tready) begin
                mval_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            act_reg  <= s_tuser;
            tid_reg  <= s_tdata[15:0];
            prio_reg <= s_tdata[23:16];
            et_reg   <= s_tdata[39:24];
            core_reg <= s_tdata[41:40];
        end
        if (fire) begin
            mdata_reg <= data_next;
            muser_reg <= st_next;
        end
    end

endmodule

// ----- test/multilevel_priority_ready_queues_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multilevel_priority_ready_queues_test
// Drives enqueue and dispatch requests into the ready queues and checks
// every result against a behavioral scheduler model kept in the bench.
// ----------------------------------------------------------------------------
module multilevel_priority_ready_queues_test;
    import mlpq_pkg::*;

    localparam int CORES = 4;
    localparam int DEPTH = 32;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic        action;
        logic [15:0] task_id;
        logic [7:0]  prio;
        logic [15:0] exec_time;
        logic [1:0]  core;
    } request_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] task_id;
        logic [1:0]  level;
        logic [11:0] slice;
        logic [7:0]  dyn_prio;
        logic [15:0] remain;
        logic [31:0] accum;
        logic        completed;
    } outcome_t;

    typedef struct {
        logic [15:0] task_id;
        logic [7:0]  sprio;
        logic [15:0] exec_time;
        logic [15:0] remain;
        logic [11:0] last_slice;
        logic [31:0] accum;
    } task_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;
    logic [2:0]  m_tuser;

    request_t pending_reqs[$];
    outcome_t expected_outcomes[$];
    task_t    ready_q[CORES][NUM_LEVELS][$];
    int       send_idle = 0;
    int       recv_stall = 0;
    bit       hold_sender = 0;
    bit       failed = 0;
    int       quiet_cycles = 0;

    multilevel_priority_ready_queues #(.NUM_CORES(CORES), .QUEUE_DEPTH(DEPTH)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #4 aclk = ~aclk;

    function automatic outcome_t schedule(request_t r);
        outcome_t o;
        task_t t;
        int lv;
        int p;
        int slice;
        int dp;
        longint acc;
        o = '0;
        if (r.action == ACT_ENQUEUE) begin
            o.task_id = r.task_id;
            if (r.prio > PRIO_MAX) begin
                o.status = ST_BAD_PRIO;
                return o;
            end
            lv = (r.prio < PRIO_LVL1) ? 0 : (r.prio < PRIO_LVL2) ? 1 : 2;
            o.level = 2'(lv);
            if (ready_q[r.core][lv].size() >= DEPTH) begin
                o.status = ST_FULL;
                return o;
            end
            t.task_id = r.task_id;
            t.sprio = r.prio;
            t.exec_time = r.exec_time;
            t.remain = r.exec_time;
            t.last_slice = '0;
            t.accum = '0;
            p = 0;
            while (p < ready_q[r.core][lv].size() && ready_q[r.core][lv][p].sprio <= r.prio)
                p++;
            ready_q[r.core][lv].insert(p, t);
            o.status = ST_ENQUEUED;
            o.dyn_prio = r.prio;
            o.remain = r.exec_time;
            return o;
        end
        for (lv = 0; lv < NUM_LEVELS; lv++)
            if (ready_q[r.core][lv].size() > 0) break;
        if (lv == NUM_LEVELS) begin
            o.status = ST_NO_TASK;
            return o;
        end
        t = ready_q[r.core][lv][0];
        p = t.sprio;
        dp = p + 5 - ((t.exec_time < t.last_slice) ? 10 : 5);
        if (dp < 100) dp = 100;
        else if (dp > 139) dp = 139;
        slice = (p < 120) ? (140 - p) * 20 : (140 - p) * 5;
        t.remain = (int'(t.remain) > slice) ? 16'(int'(t.remain) - slice) : 16'd0;
        acc = longint'(t.accum) + slice;
        t.accum = (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
        t.last_slice = 12'(slice);
        o.status = ST_DISPATCH;
        o.task_id = t.task_id;
        o.level = 2'(lv);
        o.slice = 12'(slice);
        o.dyn_prio = 8'(dp);
        o.remain = t.remain;
        o.accum = t.accum;
        if (t.remain == 0) begin
            ready_q[r.core][lv].delete(0);
            o.completed = 1'b1;
        end else begin
            ready_q[r.core][lv][0] = t;
        end
        return o;
    endfunction

    // driver
    always @(posedge aclk) begin
        request_t r;
        if (aresetn) begin
            if (!s_tvalid || s_tready) begin
                if (hold_sender || pending_reqs.size() == 0 ||
                        ($urandom_range(99) < send_idle)) begin
                    s_tvalid <= 1'b0;
                end else begin
                    r = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= r.action;
                    s_tdata <= {6'd0, r.core, r.exec_time, r.prio, r.task_id};
                    expected_outcomes.push_back(schedule(r));
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // monitor
    always @(posedge aclk) begin
        outcome_t got;
        outcome_t want;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (m_tvalid && m_tready) begin
                got = {m_tuser, m_tdata[15:0], m_tdata[17:16], m_tdata[29:18],
                       m_tdata[37:30], m_tdata[53:38], m_tdata[85:54], m_tdata[86]};
                if (expected_outcomes.size() == 0) begin
                    $display("%0t unexpected result %h", $realtime, got);
                    failed <= 1'b1;
                end else begin
                    want = expected_outcomes.pop_front();
                    if (got !== want) begin
                        $display("%0t mismatch: expected st=%0d id=%0d lv=%0d sl=%0d dp=%0d rem=%0d acc=%0d c=%0d",
                                 $realtime, want.status, want.task_id, want.level, want.slice,
                                 want.dyn_prio, want.remain, want.accum, want.completed);
                        $display("%0t           actual st=%0d id=%0d lv=%0d sl=%0d dp=%0d rem=%0d acc=%0d c=%0d",
                                 $realtime, got.status, got.task_id, got.level, got.slice,
                                 got.dyn_prio, got.remain, got.accum, got.completed);
                        failed <= 1'b1;
                    end
                end
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    function automatic request_t make_req(logic act, logic [15:0] id, logic [7:0] p,
                                          logic [15:0] et, logic [1:0] c);
        request_t r;
        r.action = act;
        r.task_id = id;
        r.prio = p;
        r.exec_time = et;
        r.core = c;
        return r;
    endfunction

    function automatic logic [7:0] rand_prio();
        int k;
        k = $urandom_range(99);
        if (k < 5) return 8'($urandom_range(255, 140));
        if (k < 40) return 8'($urandom_range(99));
        if (k < 75) return 8'($urandom_range(129, 100));
        return 8'($urandom_range(139, 130));
    endfunction

    function automatic logic [15:0] rand_exec();
        int k;
        k = $urandom_range(99);
        if (k < 70) return 16'($urandom_range(3000));
        if (k < 90) return 16'($urandom_range(65535));
        return 16'hFFFF;
    endfunction

    task automatic drain();
        while (pending_reqs.size() != 0 || expected_outcomes.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    initial begin
        int i;
        int ph;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty dispatch, extremes, invalid priority, level edges
        pending_reqs.push_back(make_req(ACT_DISPATCH, 16'hFFFF, 8'hFF, 16'hFFFF, 2'd0));
        pending_reqs.push_back(make_req(ACT_ENQUEUE, 16'd0, 8'd0, 16'd0, 2'd0));
        pending_reqs.push_back(make_req(ACT_ENQUEUE, 16'hFFFF, 8'd99, 16'hFFFF, 2'd0));
        pending_reqs.push_back(make_req(ACT_ENQUEUE, 16'd5, 8'd99, 16'd10, 2'd0));
        pending_reqs.push_back(make_req(ACT_ENQUEUE, 16'd6, 8'd100, 16'd1, 2'd1));
        pending_reqs.push_back(make_req(ACT_ENQUEUE, 16'd7, 8'd129, 16'd200, 2'd1));
        pending_reqs.push_back(make_req(ACT_ENQUEUE, 16'd8, 8'd130, 16'd5, 2'd2));
        pending_reqs.push_back(make_req(ACT_ENQUEUE, 16'd9, 8'd139, 16'd100, 2'd3));
        pending_reqs.push_back(make_req(ACT_ENQUEUE, 16'd10, 8'd140, 16'd1, 2'd3));
        pending_reqs.push_back(make_req(ACT_ENQUEUE, 16'd11, 8'd255, 16'd1, 2'd3));
        pending_reqs.push_back(make_req(ACT_ENQUEUE, 16'd12, 8'd119, 16'd50, 2'd2));
        pending_reqs.push_back(make_req(ACT_ENQUEUE, 16'd13, 8'd120, 16'd50, 2'd2));
        for (i = 0; i < 5; i++)
            pending_reqs.push_back(make_req(ACT_DISPATCH, 16'd0, 8'd0, 16'd0, 2'd0));
        for (i = 0; i < 4; i++)
            pending_reqs.push_back(make_req(ACT_DISPATCH, 16'd0, 8'd0, 16'd0, i[1:0]));
        pending_reqs.push_back(make_req(ACT_DISPATCH, 16'd0, 8'd0, 16'd0, 2'd1));
        pending_reqs.push_back(make_req(ACT_DISPATCH, 16'd0, 8'd0, 16'd0, 2'd3));
        drain();

        // fill one queue to its depth and overflow it
        for (i = 0; i < DEPTH + 2; i++)
            pending_reqs.push_back(make_req(ACT_ENQUEUE, 16'($urandom),
                                            8'($urandom_range(139, 130)),
                                            16'($urandom_range(200)), 2'd3));
        hold_sender = 1;
        repeat (3) @(posedge aclk);
        hold_sender = 0;
        drain();

        for (ph = 0; ph < 4; ph++) begin
            send_idle = (ph == 1 || ph == 3) ? 75 : 0;
            recv_stall = (ph == 2 || ph == 3) ? 75 : 0;
            if (ph == 3) begin
                send_idle = 7;
                recv_stall = 7;
            end
            for (i = 0; i < 75; i++) begin
                if ($urandom_range(99) < 55)
                    pending_reqs.push_back(make_req(ACT_ENQUEUE, 16'($urandom), rand_prio(),
                                                    rand_exec(), 2'($urandom_range(3))));
                else
                    pending_reqs.push_back(make_req(ACT_DISPATCH, 16'($urandom),
                                                    8'($urandom), 16'($urandom),
                                                    2'($urandom_range(3))));
            end
            drain();
        end
        // dispatches on random cores to pull out more of what is left
        send_idle = 0;
        recv_stall = 0;
        for (i = 0; i < 60; i++)
            pending_reqs.push_back(make_req(ACT_DISPATCH, 16'd0, 8'd0, 16'd0,
                                            2'($urandom_range(3))));
        drain();

        if (!failed) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/mlpq_pkg.sv
rtl/mlpq_cell.sv
rtl/mlpq_queue.sv
rtl/multilevel_priority_ready_queues.sv
test/multilevel_priority_ready_queues_test.sv
